>>> rtl/dmq_pkg.sv
package dmq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 5;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W      = PTR_W + 1;

    // Record fields
    localparam int ID_W    = 14;
    localparam int HGT_W   = 8;
    localparam int ENTRY_W = ID_W + HGT_W;
    localparam int OCC_W   = 3;

    // Sum of all queued heights
    localparam int SUM_W = $clog2(255 * QUEUE_DEPTH + 1);

    // Mean by reciprocal multiply: floor(m * RECIP(c) >> RECIP_SHIFT) == floor(m / c)
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int NUM_W       = SUM_W + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERT = 2'd0;
    localparam logic [1:0] ST_REMOVE = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // Request from the controller to the mean unit
    typedef struct packed {
        logic start;
        sum_t sum;
        cnt_t count;
    } mean_req_t;

    // ceil(2^16 / c) for counts 1..16; exact for every numerator the queue produces
    function automatic logic [RECIP_W-1:0] recip_of(input logic [4:0] c);
        logic [RECIP_W-1:0] r;
        case (c)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4096;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dmq_ram.sv
module dmq_ram #(
    parameter int DEPTH  = 5,
    parameter int WIDTH  = 22,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dmq_mean.sv
module dmq_mean (
    input  logic              aclk,
    input  dmq_pkg::mean_req_t req,
    output logic [7:0]        mean
);
    import dmq_pkg::*;

    logic [NUM_W-1:0]   num;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;

    // floor((2*sum + c) / (2*c)) == floor((sum + floor(c/2)) / c)
    assign num       = NUM_W'(req.sum) + NUM_W'(req.count >> 1);
    assign recip     = recip_of(5'(req.count));
    assign prod_next = PROD_W'(num) * PROD_W'(recip);

    // Register the product before taking the quotient
    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg <= prod_next;
        end
    end

    assign mean = prod_reg[RECIP_SHIFT +: 8];

endmodule

>>> rtl/drop_oldest_queue_average.sv
// Bounded record queue of QUEUE_DEPTH entries (identifier and height) with a running
// mean of the queued heights. An insert appends the new record, silently dropping the
// oldest record first if the queue is full, and reports the mean height rounded half
// up; a remove pops the oldest record and reports it, or reports an empty status with
// no change. Records live in a one-port-write, one-port-read memory with a registered
// read port; the oldest pointer, count and height sum live in registers. One request
// is worked at a time. With the output register free, an insert into a non-full
// queue writes, computes the mean and loads the output; an insert into a full queue
// first reads the oldest record; a remove from a non-empty queue reads and loads the
// output, and a remove on an empty queue goes straight to the output load. The next
// request is taken in the cycle after the result is loaded, even while that result
// still waits on m_tready. No clearing pass follows reset.
module drop_oldest_queue_average (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // player_id[13:0], player_height[21:14], zero pad
    input  logic        s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // mean_height[7:0], removed_id[21:8],
                                   // removed_height[29:22], occupancy[32:30], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import dmq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MEAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             req_reg, req_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [HGT_W-1:0] hgt_reg, hgt_next;
    ptr_t             ptr_reg, ptr_next;
    cnt_t             count_reg, count_next;
    sum_t             sum_reg, sum_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [ID_W-1:0]  res_id_reg, res_id_next;
    logic [HGT_W-1:0] res_hgt_reg, res_hgt_next;
    logic             m_valid_reg, m_valid_next;
    logic [39:0]      m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;

    logic             s_beat;
    logic             out_free;
    logic             in_req;
    logic [ID_W-1:0]  in_id;
    logic [HGT_W-1:0] in_hgt;
    logic [SLOT_W-1:0] slot_sum;
    ptr_t             tail_slot;
    ptr_t             ptr_inc;
    logic             wr_en;
    ptr_t             wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    entry_t           rd_data;
    logic [ID_W-1:0]  rd_id;
    logic [HGT_W-1:0] rd_hgt;
    mean_req_t        mean_req;
    logic [7:0]       mean;
    logic [7:0]       mean_out;

    assign in_req = s_tuser;
    assign in_id  = s_tdata[ID_W-1:0];
    assign in_hgt = s_tdata[ID_W +: HGT_W];

    assign s_tready = (state_reg == S_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Tail slot and pointer advance, both wrapping at the queue depth
    assign slot_sum  = SLOT_W'(ptr_reg) + SLOT_W'(count_reg);
    assign tail_slot = (slot_sum >= SLOT_W'(QUEUE_DEPTH))
                       ? PTR_W'(slot_sum - SLOT_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
    assign ptr_inc   = (ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);

    assign rd_id  = rd_data[HGT_W +: ID_W];
    assign rd_hgt = rd_data[HGT_W-1:0];

    // Sequence one request: accept, optional oldest read, mean for inserts, output load
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        hgt_next        = hgt_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_hgt_next    = res_hgt_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_slot;
        wr_data         = {in_id, in_hgt};
        rd_en           = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    req_next     = in_req;
                    id_next      = in_id;
                    hgt_next     = in_hgt;
                    res_id_next  = '0;
                    res_hgt_next = '0;
                    if (in_req == REQ_INSERT) begin
                        res_status_next = ST_INSERT;
                        if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                            // full: fetch the oldest height before dropping it
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            sum_next   = sum_reg + SUM_W'(in_hgt);
                            state_next = S_MEAN;
                        end
                    end else if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_DONE;
                    end else begin
                        res_status_next = ST_REMOVE;
                        rd_en           = 1'b1;
                        state_next      = S_READ;
                    end
                end
            end
            S_READ: begin
                ptr_next = ptr_inc;
                if (req_reg == REQ_INSERT) begin
                    // drop oldest, append new in the freed slot
                    wr_en      = 1'b1;
                    wr_addr    = ptr_reg;
                    wr_data    = {id_reg, hgt_reg};
                    sum_next   = sum_reg - SUM_W'(rd_hgt) + SUM_W'(hgt_reg);
                    state_next = S_MEAN;
                end else begin
                    count_next   = count_reg - CNT_W'(1);
                    sum_next     = sum_reg - SUM_W'(rd_hgt);
                    res_id_next  = rd_id;
                    res_hgt_next = rd_hgt;
                    state_next   = S_DONE;
                end
            end
            S_MEAN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {7'd0, OCC_W'(count_reg), res_hgt_reg, res_id_reg,
                                    mean_out};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mean_out = (res_status_reg == ST_INSERT) ? mean : 8'd0;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        id_reg         <= id_next;
        hgt_reg        <= hgt_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_hgt_reg    <= res_hgt_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    // Reads and writes never meet on one entry: a request writes at most once and
    // the next request's read comes in a later cycle.
    dmq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Mean over the updated sum and count
    assign mean_req.start = (state_reg == S_MEAN);
    assign mean_req.sum   = sum_reg;
    assign mean_req.count = count_reg;

    dmq_mean u_mean (
        .aclk (aclk),
        .req  (mean_req),
        .mean (mean)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_empty_remove_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && in_req == REQ_REMOVE && count_reg == '0) |=>
        (count_reg == $past(count_reg) && ptr_reg == $past(ptr_reg)
         && sum_reg == $past(sum_reg)))
        else $error("empty remove changed queue state");

    a_insert_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MEAN) |-> (count_reg != '0))
        else $error("mean computed over an empty queue");
`endif

endmodule
